// File: rtl/core/irsc_pkg.sv
package irsc_pkg;

  localparam int DIM_BITS = 13;
  localparam int FRAC_BITS = 16;
  localparam int SCL_BITS = DIM_BITS + FRAC_BITS;
  localparam int PROD_BITS = SCL_BITS + DIM_BITS;

  // config register indexes
  localparam int CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_LEN = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAP_LEN = 8'd1;

  localparam logic [DIM_BITS-1:0] TGT_LEN_RST = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0] CAP_LEN_RST = DIM_BITS'(1333);

  // stream packing
  localparam int IN_BYTES = (2 * DIM_BITS + 7) / 8;
  localparam int OUT_FIELD_BITS = 2 * DIM_BITS + 3 * SCL_BITS;
  localparam int OUT_BYTES = (OUT_FIELD_BITS + 7) / 8;

  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [SCL_BITS-1:0] scl_t;

endpackage

// File: rtl/core/irsc_div.sv
module irsc_div (
  input  logic                  clk,
  input  logic                  en,
  input  irsc_pkg::scl_t        num,
  input  irsc_pkg::dim_t        den,
  output irsc_pkg::scl_t        quo
);
  import irsc_pkg::*;

  // one quotient bit per stage, restoring division, msb first
  scl_t num_r [SCL_BITS];
  scl_t quo_r [SCL_BITS];
  dim_t den_r [SCL_BITS];
  dim_t rem_r [SCL_BITS];

  for (genvar k = 0; k < SCL_BITS; k++) begin : g_stage
    scl_t                num_i;
    scl_t                quo_i;
    dim_t                den_i;
    dim_t                rem_i;
    logic [DIM_BITS:0]   trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign num_i = num;
      assign quo_i = '0;
      assign den_i = den;
      assign rem_i = '0;
    end else begin : g_next
      assign num_i = num_r[k-1];
      assign quo_i = quo_r[k-1];
      assign den_i = den_r[k-1];
      assign rem_i = rem_r[k-1];
    end

    // trial subtract of the next dividend bit
    assign trial = {rem_i, num_i[SCL_BITS-1]};
    assign ge = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_i[SCL_BITS-2:0], 1'b0};
        quo_r[k] <= {quo_i[SCL_BITS-2:0], ge};
        den_r[k] <= den_i;
        rem_r[k] <= ge ? DIM_BITS'(trial - {1'b0, den_i}) : DIM_BITS'(trial);
      end
    end
  end

  assign quo = quo_r[SCL_BITS-1];

endmodule

// File: rtl/core/image_resize_scale_calc.sv
// Resize scale calculator: per image descriptor (height, width) it picks the uniform
// Q13.16 scale target length / shorter side, falls back to length cap / longer side when
// the rounded longer side would pass the cap, and returns scaled sizes and per-axis
// scales. Fully pipelined: one request per cycle while the output is not held, through
// two chains of 29 restoring divider stages (one quotient bit per stage). A zero
// dimension raises the tuser error flag with all tdata fields zero. Config writes are
// always accepted and must only happen while the pipeline is empty.
module image_resize_scale_calc (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // height, width
  input  logic [8*irsc_pkg::IN_BYTES-1:0]          s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // scaled_height, scaled_width, uniform_scale, scale_y, scale_x
  output logic [8*irsc_pkg::OUT_BYTES-1:0]         m_axis_tdata,
  // zero_dim_error
  output logic                                     m_axis_tuser,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [irsc_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [irsc_pkg::DIM_BITS-1:0]            cfg_data
);
  import irsc_pkg::*;

  localparam int QB = SCL_BITS;
  localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

  dim_t tgt_len;
  dim_t cap_len;
  logic en;

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_len <= TGT_LEN_RST;
      cap_len <= CAP_LEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TGT_LEN) tgt_len <= cfg_data;
      if (cfg_index == REG_CAP_LEN) cap_len <= cfg_data;
    end
  end

  // whole pipeline moves together unless the output is held
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: register request, order sides
  logic v0, z0;
  dim_t h0, w0, mn0, mx0;
  scl_t tnum0, mnum0;
  dim_t hin, win;
  assign hin = s_axis_tdata[DIM_BITS-1:0];
  assign win = s_axis_tdata[2*DIM_BITS-1:DIM_BITS];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h0 <= hin;
      w0 <= win;
      z0 <= (hin == '0) || (win == '0);
      mn0 <= (hin < win) ? hin : win;
      mx0 <= (hin < win) ? win : hin;
      tnum0 <= {tgt_len, FRAC_BITS'(0)};
      mnum0 <= {cap_len, FRAC_BITS'(0)};
    end
  end

  // first divider pair: uncapped and capped scale
  scl_t s_free, s_cap;
  irsc_div u_div_free (.clk(clk), .en(en), .num(tnum0), .den(mn0), .quo(s_free));
  irsc_div u_div_cap (.clk(clk), .en(en), .num(mnum0), .den(mx0), .quo(s_cap));

  // sideband alongside the first dividers
  logic va [QB];
  logic za [QB];
  dim_t ha [QB];
  dim_t wa [QB];
  dim_t mxa [QB];
  dim_t maxa [QB];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QB; i++) va[i] <= 1'b0;
    end else if (en) begin
      va[0] <= v0;
      for (int i = 1; i < QB; i++) va[i] <= va[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      za[0] <= z0;
      ha[0] <= h0;
      wa[0] <= w0;
      mxa[0] <= mx0;
      maxa[0] <= cap_len;
      for (int i = 1; i < QB; i++) begin
        za[i] <= za[i-1];
        ha[i] <= ha[i-1];
        wa[i] <= wa[i-1];
        mxa[i] <= mxa[i-1];
        maxa[i] <= maxa[i-1];
      end
    end
  end

  // stage 1: longer side times uncapped scale
  logic v1, z1;
  dim_t h1, w1, max1;
  scl_t sf1, sc1;
  logic [PROD_BITS-1:0] prod1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= va[QB-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z1 <= za[QB-1];
      h1 <= ha[QB-1];
      w1 <= wa[QB-1];
      max1 <= maxa[QB-1];
      sf1 <= s_free;
      sc1 <= s_cap;
      prod1 <= PROD_BITS'(s_free) * PROD_BITS'(mxa[QB-1]);
    end
  end

  // stage 2: round half up, cap test, pick scale
  logic v2, z2;
  dim_t h2, w2;
  scl_t s2;
  logic [PROD_BITS-FRAC_BITS-1:0] rounded;
  assign rounded = (PROD_BITS-FRAC_BITS)'((prod1 + HALF) >> FRAC_BITS);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z2 <= z1;
      h2 <= h1;
      w2 <= w1;
      s2 <= (rounded > (PROD_BITS-FRAC_BITS)'(max1)) ? sc1 : sf1;
    end
  end

  // stage 3: scaled size products
  logic v3, z3;
  dim_t h3, w3;
  scl_t s3;
  logic [PROD_BITS-1:0] hp3, wp3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z3 <= z2;
      h3 <= h2;
      w3 <= w2;
      s3 <= s2;
      hp3 <= PROD_BITS'(h2) * PROD_BITS'(s2);
      wp3 <= PROD_BITS'(w2) * PROD_BITS'(s2);
    end
  end

  // stage 4: truncate and saturate scaled sizes
  logic v4, z4;
  dim_t h4, w4, sh4, sw4;
  scl_t s4;
  logic [PROD_BITS-FRAC_BITS-1:0] hq, wq;
  assign hq = (PROD_BITS-FRAC_BITS)'(hp3 >> FRAC_BITS);
  assign wq = (PROD_BITS-FRAC_BITS)'(wp3 >> FRAC_BITS);
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z4 <= z3;
      h4 <= h3;
      w4 <= w3;
      s4 <= s3;
      sh4 <= (hq > (PROD_BITS-FRAC_BITS)'({DIM_BITS{1'b1}})) ? '1 : DIM_BITS'(hq);
      sw4 <= (wq > (PROD_BITS-FRAC_BITS)'({DIM_BITS{1'b1}})) ? '1 : DIM_BITS'(wq);
    end
  end

  // second divider pair: per-axis scales
  scl_t sy_q, sx_q;
  irsc_div u_div_y (.clk(clk), .en(en), .num({sh4, FRAC_BITS'(0)}), .den(h4), .quo(sy_q));
  irsc_div u_div_x (.clk(clk), .en(en), .num({sw4, FRAC_BITS'(0)}), .den(w4), .quo(sx_q));

  logic vb [QB];
  logic zb [QB];
  dim_t shb [QB];
  dim_t swb [QB];
  scl_t sb [QB];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QB; i++) vb[i] <= 1'b0;
    end else if (en) begin
      vb[0] <= v4;
      for (int i = 1; i < QB; i++) vb[i] <= vb[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zb[0] <= z4;
      shb[0] <= sh4;
      swb[0] <= sw4;
      sb[0] <= s4;
      for (int i = 1; i < QB; i++) begin
        zb[i] <= zb[i-1];
        shb[i] <= shb[i-1];
        swb[i] <= swb[i-1];
        sb[i] <= sb[i-1];
      end
    end
  end

  // output register, zero dimension clears all fields
  logic zo;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= vb[QB-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zo <= zb[QB-1];
      m_axis_tdata <= zb[QB-1] ? '0 :
        (8*OUT_BYTES)'({sx_q, sy_q, sb[QB-1], swb[QB-1], shb[QB-1]});
    end
  end
  assign m_axis_tuser = zo;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result carries nonzero fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output stall");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
